@@ rtl/core/prct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prct_pkg
// Shared types, constants and the arctangent table for the pivot rotation
// coordinate transform.
// ----------------------------------------------------------------------------
package prct_pkg;

	localparam int COORD_BITS_DEF    = 32;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int CW = COORD_BITS_DEF;
	localparam int AW = ANGLE_BITS_DEF;

	localparam logic [1:0] MODE_P2C    = 2'd0;
	localparam logic [1:0] MODE_C2P    = 2'd1;
	localparam logic [1:0] MODE_EXTENT = 2'd2;

	localparam int ZW = 33;
	localparam int XYW = 34;
	localparam logic signed [XYW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

	typedef struct packed {
		logic [1:0]           mode;
		logic signed [CW-1:0] in_x;
		logic signed [CW-1:0] in_y;
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pivot_x;
		logic signed [CW-1:0] pivot_y;
		logic signed [AW-1:0] angle;
		logic [CW-2:0]        width;
		logic [CW-2:0]        height;
	} prct_in_t;

	typedef struct packed {
		logic signed [CW-1:0] out_x;
		logic signed [CW-1:0] out_y;
		logic                 saturated;
	} prct_out_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 33'sh3243F6A8;
			1: r = 33'sh1DAC6705;
			2: r = 33'sh0FADBAFC;
			3: r = 33'sh07F56EA6;
			4: r = 33'sh03FEAB76;
			5: r = 33'sh01FFD55B;
			6: r = 33'sh00FFFAAA;
			7: r = 33'sh007FFF55;
			8: r = 33'sh003FFFEA;
			9: r = 33'sh001FFFFD;
			10: r = 33'sh000FFFFF;
			11: r = 33'sh0007FFFF;
			12: r = 33'sh0003FFFF;
			13: r = 33'sh0001FFFF;
			14: r = 33'sh0000FFFF;
			15: r = 33'sh00007FFF;
			16: r = 33'sh00003FFF;
			17: r = 33'sh00001FFF;
			18: r = 33'sh00000FFF;
			19: r = 33'sh000007FF;
			20: r = 33'sh000003FF;
			21: r = 33'sh000001FF;
			22: r = 33'sh000000FF;
			23: r = 33'sh0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/prct_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prct_cordic
// Pipelined rotation CORDIC: one micro-rotation per stage, an angle scaling
// stage in front and a quadrant/round stage behind. Advances when en is high.
// ----------------------------------------------------------------------------
module prct_cordic import prct_pkg::*; #(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int TF            = 30
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output logic signed [TF+1:0]       cos_o,
	output logic signed [TF+1:0]       sin_o
);
	localparam int RB = ANGLE_BITS - 2;

	logic [1:0]           quad_s1;
	logic signed [ZW-1:0] z_s1;
	logic [RB+30:0]       prod;

	assign prod = {31'd0, angle[RB-1:0]} * {{RB{1'b0}}, PI_HALF_Q30};

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= angle[ANGLE_BITS-1 -: 2];
			z_s1    <= ZW'(prod >> RB);
		end
	end

	logic signed [XYW-1:0] x_p [0:CORDIC_STAGES];
	logic signed [XYW-1:0] y_p [0:CORDIC_STAGES];
	logic signed [ZW-1:0]  z_p [0:CORDIC_STAGES];
	logic [1:0]            q_p [0:CORDIC_STAGES];

	assign x_p[0] = CORDIC_GAIN;
	assign y_p[0] = '0;
	assign z_p[0] = z_s1;
	assign q_p[0] = quad_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				q_p[i+1] <= q_p[i];
				if (!z_p[i][ZW-1]) begin
					x_p[i+1] <= x_p[i] - (y_p[i] >>> i);
					y_p[i+1] <= y_p[i] + (x_p[i] >>> i);
					z_p[i+1] <= z_p[i] - atan_q30(i);
				end else begin
					x_p[i+1] <= x_p[i] + (y_p[i] >>> i);
					y_p[i+1] <= y_p[i] - (x_p[i] >>> i);
					z_p[i+1] <= z_p[i] + atan_q30(i);
				end
			end
		end
	end

	logic signed [XYW-1:0] xf, yf, cr, sr;
	assign xf = x_p[CORDIC_STAGES];
	assign yf = y_p[CORDIC_STAGES];

	always_comb begin
		case (q_p[CORDIC_STAGES])
			2'd0: begin cr = xf;  sr = yf;  end
			2'd1: begin cr = -yf; sr = xf;  end
			2'd2: begin cr = -xf; sr = -yf; end
			default: begin cr = yf; sr = -xf; end
		endcase
	end

	function automatic logic signed [TF+1:0] to_trig(input logic signed [XYW-1:0] v);
		localparam int S = 30 - TF;
		logic signed [XYW:0] t;
		logic signed [XYW:0] one;
		one = (XYW+1)'(1) <<< TF;
		if (S > 0) t = ({v[XYW-1], v} + ((XYW+1)'(1) <<< (S > 0 ? S-1 : 0))) >>> S;
		else t = {v[XYW-1], v};
		if (t > one) t = one;
		if (t < -one) t = -one;
		return t[TF+1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= to_trig(cr);
			sin_o <= to_trig(sr);
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/prct_combine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prct_combine
// Two products in parallel, registered; then sum, round, offset and clamp.
// ----------------------------------------------------------------------------
module prct_combine import prct_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TF         = 30
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic signed [COORD_BITS:0]   d1,
	input  wire logic signed [TF+1:0]         c1,
	input  wire logic signed [COORD_BITS:0]   d2,
	input  wire logic signed [TF+1:0]         c2,
	input  wire logic signed [COORD_BITS-1:0] off,
	output logic signed [COORD_BITS-1:0]      res,
	output logic                              sat
);
	localparam int PW = COORD_BITS + TF + 3;
	localparam int SW = PW + 1;

	logic signed [PW-1:0]         p1_s1, p2_s1;
	logic signed [COORD_BITS-1:0] off_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= PW'(d1) * PW'(c1);
			p2_s1  <= PW'(d2) * PW'(c2);
			off_s1 <= off;
		end
	end

	logic signed [SW-1:0] acc, v, hi, lo;
	assign acc = SW'(p1_s1) + SW'(p2_s1) + (SW'(1) <<< (TF-1));
	assign v   = (acc >>> TF) + SW'(off_s1);
	assign hi  = SW'({1'b0, {(COORD_BITS-1){1'b1}}});
	assign lo  = -hi - SW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			if (v > hi) begin
				res <= hi[COORD_BITS-1:0];
				sat <= 1'b1;
			end else if (v < lo) begin
				res <= lo[COORD_BITS-1:0];
				sat <= 1'b1;
			end else begin
				res <= v[COORD_BITS-1:0];
				sat <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pivot_rotate_coordinate_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pivot_rotate_coordinate_transform
// Rotation about a pivot with translation, CORDIC sine/cosine, saturation.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle unless stalled. The stages are
// angle scaling, CORDIC_STAGES micro-rotations, quadrant and round, product,
// sum and clamp. Point differences and corner selection travel alongside
// the CORDIC in delay registers. The pipeline stalls as a whole when a valid
// output is not taken; the output register holds its transaction meanwhile.
module pivot_rotate_coordinate_transform import prct_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire prct_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output prct_out_t      out_data
);
	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int ANGLE_BITS = ANGLE_BITS_DEF;
	localparam int TF  = (62 - COORD_BITS) < 30 ? (62 - COORD_BITS) : 30;
	localparam int LAT = CORDIC_STAGES + 4;
	localparam int DL  = CORDIC_STAGES + 2;

	logic en;
	logic [LAT-1:0] vld_q;

	assign en       = !out_valid || out_ready || !vld_q[LAT-1];
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// front: operand differences and corner selection
	logic [1:0] mode;
	logic [ANGLE_BITS-1:0] ang;
	logic [1:0] quad;
	logic signed [COORD_BITS:0] px, py, ox, oy, vx, vy, w, h;
	logic signed [COORD_BITS:0] a1, a2, b1, b2, wx, wy, hx, hy;
	logic signed [COORD_BITS-1:0] offx, offy;
	logic sneg1, sneg2, zero;

	assign mode = in_data.mode;
	assign ang  = ANGLE_BITS'(in_data.angle);
	assign quad = ang[ANGLE_BITS-1 -: 2];
	assign px = (COORD_BITS+1)'(in_data.in_x);
	assign py = (COORD_BITS+1)'(in_data.in_y);
	assign ox = (COORD_BITS+1)'(in_data.pos_x);
	assign oy = (COORD_BITS+1)'(in_data.pos_y);
	assign vx = (COORD_BITS+1)'(in_data.pivot_x);
	assign vy = (COORD_BITS+1)'(in_data.pivot_y);
	assign w  = (COORD_BITS+1)'({1'b0, in_data.width});
	assign h  = (COORD_BITS+1)'({1'b0, in_data.height});

	always_comb begin
		case (quad)
			2'd2: begin wx = '0; wy = h;  hx = '0; hy = '0; end
			2'd3: begin wx = w;  wy = h;  hx = '0; hy = h;  end
			2'd0: begin wx = w;  wy = '0; hx = w;  hy = h;  end
			default: begin wx = '0; wy = '0; hx = w; hy = '0; end
		endcase
		zero = 1'b0;
		case (mode)
			MODE_P2C: begin
				a1 = px - ox; a2 = py - oy; b1 = py - oy; b2 = px - ox;
				offx = in_data.pivot_x; offy = in_data.pivot_y;
				sneg1 = 1'b0; sneg2 = 1'b1;
			end
			MODE_C2P: begin
				a1 = px - vx; a2 = py - vy; b1 = py - vy; b2 = px - vx;
				offx = in_data.pos_x; offy = in_data.pos_y;
				sneg1 = 1'b1; sneg2 = 1'b0;
			end
			MODE_EXTENT: begin
				a1 = wx - vx; a2 = wy - vy; b1 = hy - vy; b2 = hx - vx;
				offx = in_data.pos_x; offy = in_data.pos_y;
				sneg1 = 1'b1; sneg2 = 1'b0;
			end
			default: begin
				a1 = '0; a2 = '0; b1 = '0; b2 = '0;
				offx = '0; offy = '0;
				sneg1 = 1'b0; sneg2 = 1'b0; zero = 1'b1;
			end
		endcase
	end

	// delay line matching the CORDIC latency
	localparam int DW = 4*(COORD_BITS+1) + 2*COORD_BITS + 3;
	logic [DW-1:0] dly_q [0:DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= {a1, a2, b1, b2, offx, offy, sneg1, sneg2, zero};
			for (int i = 1; i < DL; i++) dly_q[i] <= dly_q[i-1];
		end
	end

	logic signed [TF+1:0] cs, sn;
	prct_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .TF(TF)) u_cordic (
		.clk(clk), .en(en), .angle(ang), .cos_o(cs), .sin_o(sn)
	);

	logic signed [COORD_BITS:0] da1, da2, db1, db2;
	logic signed [COORD_BITS-1:0] dox, doy;
	logic dsn1, dsn2, dz;
	assign {da1, da2, db1, db2, dox, doy, dsn1, dsn2, dz} = dly_q[DL-1];

	logic signed [TF+1:0] s1, s2;
	assign s1 = dsn1 ? -sn : sn;
	assign s2 = dsn2 ? -sn : sn;

	// unused mode: zero operands give zero products; hold a flag to clear rounding
	logic [1:0] z_p;
	always_ff @(posedge clk) begin
		if (en) z_p <= {z_p[0], dz};
	end

	logic signed [COORD_BITS-1:0] rx, ry;
	logic satx, saty;

	prct_combine #(.COORD_BITS(COORD_BITS), .TF(TF)) u_cx (
		.clk(clk), .en(en), .d1(da1), .c1(cs), .d2(da2), .c2(s1), .off(dox),
		.res(rx), .sat(satx)
	);
	prct_combine #(.COORD_BITS(COORD_BITS), .TF(TF)) u_cy (
		.clk(clk), .en(en), .d1(db1), .c1(cs), .d2(db2), .c2(s2), .off(doy),
		.res(ry), .sat(saty)
	);

	assign out_data.out_x     = z_p[1] ? '0 : rx;
	assign out_data.out_y     = z_p[1] ? '0 : ry;
	assign out_data.saturated = !z_p[1] && (satx || saty);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("pipeline stalled without backpressure");
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a waiting output");

endmodule
`default_nettype wire

@@ bench/prct_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prct_checker
// Watches both channels of the pivot rotation transform, computes the
// expected result of every accepted input transaction with a bit-exact
// CORDIC and rotation model, and compares each output transaction in order.
// ----------------------------------------------------------------------------
module prct_checker import prct_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire prct_in_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire prct_out_t out_data,
	output int             errors,
	output int             pending
);

	prct_out_t transform_q[$];

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint trig_round(longint q30);
		longint v;
		v = q30;
		if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
		if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
		return v;
	endfunction

	function automatic longint atan_entry(int i);
		longint t[16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
			64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
			64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
		return t[i];
	endfunction

	function automatic void rotate_terms(logic [15:0] ang, output longint c,
		output longint s);
		longint x, y, z, xs, ys;
		logic [63:0] r;
		x = 64'sd652032874;
		y = 0;
		r = {50'd0, ang[13:0]};
		z = longint'((r * 64'd1686629713) >> 14);
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_entry(i);
			end else begin
				x += ys; y -= xs; z += atan_entry(i);
			end
		end
		case (ang[15:14])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		c = trig_round(c);
		s = trig_round(s);
	endfunction

	function automatic longint mix_clamp(longint d1, longint c1, longint d2,
		longint c2, longint off, inout logic sat);
		longint v;
		v = floor_shr(d1 * c1 + d2 * c2 + (64'sd1 <<< 29), 30) + off;
		if (v > 64'sd2147483647) begin sat = 1'b1; return 64'sd2147483647; end
		if (v < -64'sd2147483648) begin sat = 1'b1; return -64'sd2147483648; end
		return v;
	endfunction

	function automatic prct_out_t transform(prct_in_t t);
		prct_out_t r;
		longint c, s, px, py, ox, oy, vx, vy, w, h, wx, wy, hx, hy, rx, ry;
		logic sat;
		sat = 1'b0;
		rx = 0;
		ry = 0;
		px = t.in_x; py = t.in_y; ox = t.pos_x; oy = t.pos_y;
		vx = t.pivot_x; vy = t.pivot_y;
		w = {33'd0, t.width}; h = {33'd0, t.height};
		rotate_terms(t.angle, c, s);
		if (t.mode == MODE_P2C) begin
			rx = mix_clamp(px - ox, c, py - oy, s, vx, sat);
			ry = mix_clamp(py - oy, c, px - ox, -s, vy, sat);
		end else if (t.mode == MODE_C2P) begin
			rx = mix_clamp(px - vx, c, py - vy, -s, ox, sat);
			ry = mix_clamp(py - vy, c, px - vx, s, oy, sat);
		end else if (t.mode == MODE_EXTENT) begin
			case (t.angle[15:14])
				2'd2: begin wx = 0; wy = h; hx = 0; hy = 0; end
				2'd3: begin wx = w; wy = h; hx = 0; hy = h; end
				2'd0: begin wx = w; wy = 0; hx = w; hy = h; end
				default: begin wx = 0; wy = 0; hx = w; hy = 0; end
			endcase
			rx = mix_clamp(wx - vx, c, wy - vy, -s, ox, sat);
			ry = mix_clamp(hy - vy, c, hx - vx, s, oy, sat);
		end
		r.out_x = rx[31:0];
		r.out_y = ry[31:0];
		r.saturated = sat;
		return r;
	endfunction

	assign pending = transform_q.size();

	always @(posedge clk or negedge arst_n) begin
		prct_out_t e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && in_ready)
				transform_q.push_back(transform(in_data));
			if (out_valid && out_ready) begin
				if (transform_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %h", out_data);
					errors <= errors + 1;
				end else begin
					e = transform_q.pop_front();
					if (e !== out_data) begin
						if (errors < 10)
							$display("mismatch exp x=%h y=%h s=%b got x=%h y=%h s=%b",
								e.out_x, e.out_y, e.saturated,
								out_data.out_x, out_data.out_y, out_data.saturated);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

@@ bench/pivot_rotate_coordinate_transform_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivot_rotate_coordinate_transform_tb
// Drives directed and random points through every mode with random gaps and
// output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module pivot_rotate_coordinate_transform_tb;
	import prct_pkg::*;

	localparam int LATENCY = 20;
	localparam int WATCHDOG = 20000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	prct_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	prct_out_t out_data;
	int        errors, pending;
	int        idle_cycles = 0;
	bit        hold_off = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pivot_rotate_coordinate_transform u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	prct_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .errors(errors), .pending(pending)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] coord_pick();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
		endcase
	endfunction

	function automatic prct_in_t random_point();
		prct_in_t t;
		t.mode = ($urandom_range(0, 39) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		t.in_x = coord_pick(); t.in_y = coord_pick();
		t.pos_x = coord_pick(); t.pos_y = coord_pick();
		t.pivot_x = coord_pick(); t.pivot_y = coord_pick();
		t.angle = 16'($urandom());
		t.width = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 300 << 16));
		t.height = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 300 << 16));
		return t;
	endfunction

	task automatic send(prct_in_t t);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		prct_in_t t;
		logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'h7FFF, 16'hFFFF, 16'h3FFF, 16'h2000};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			t = '0;
			t.mode = 2'(i % 3);
			t.angle = angles[i];
			t.in_x = 32'sd5 <<< 16; t.in_y = -(32'sd3 <<< 16);
			t.pos_x = 32'sd1 <<< 16; t.pivot_y = 32'sd2 <<< 16;
			t.width = 31'd10 << 16; t.height = 31'd4 << 16;
			send(t);
		end
		for (int i = 0; i < 12; i++) begin
			t.mode = 2'(i % 4);
			t.angle = angles[i % 8];
			t.in_x = (i & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			t.in_y = (i & 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
			t.pos_x = ~t.in_x; t.pos_y = ~t.in_y;
			t.pivot_x = t.in_y; t.pivot_y = t.in_x;
			t.width = (i & 1) ? 31'h7FFF_FFFF : 31'd0;
			t.height = (i & 2) ? 31'd0 : 31'h7FFF_FFFF;
			send(t);
		end
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 60; i++) begin
				t = random_point();
				send(t);
			end
		join
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		@(negedge clk);
		for (int i = 0; i < 1400; i++) begin
			t = random_point();
			send(t);
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
